>>> sv/pgg_pkg.sv
// Shared types, constants and the arctangent table for the polar go-to-goal controller.
`default_nettype none

package pgg_pkg;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } pgg_in_t;

  typedef struct packed {
    logic        [30:0] linear_velocity;
    logic signed [31:0] angular_velocity;
    logic        [31:0] dist_to_goal;
  } pgg_out_t;

  typedef enum logic [2:0] {
    REG_GOAL_X       = 3'd0,
    REG_GOAL_Y       = 3'd1,
    REG_GAIN_DIST    = 3'd2,
    REG_GAIN_HEADING = 3'd3,
    REG_GAIN_BEARING = 3'd4,
    REG_STOP_TOL     = 3'd5
  } pgg_reg_e;

  // CORDIC operand width at the unit input, datapath width, angle widths
  localparam int InW     = 36;
  localparam int CordicW = 44;
  localparam int NormW   = 41;
  localparam int AngW    = 20;
  localparam int OutAngW = 17;
  localparam int SqrtLat = 34;

  localparam logic signed [AngW-1:0] HalfPiQ16 = 20'sd102944;

  // round(atan(2^-i) * 2^16), zero from i = 17 on
  function automatic logic signed [AngW-1:0] atan_q16(input int i);
    logic signed [AngW-1:0] a;
    case (i)
      0:       a = 20'sd51472;
      1:       a = 20'sd30386;
      2:       a = 20'sd16055;
      3:       a = 20'sd8150;
      4:       a = 20'sd4091;
      5:       a = 20'sd2047;
      6:       a = 20'sd1024;
      7:       a = 20'sd512;
      8:       a = 20'sd256;
      9:       a = 20'sd128;
      10:      a = 20'sd64;
      11:      a = 20'sd32;
      12:      a = 20'sd16;
      13:      a = 20'sd8;
      14:      a = 20'sd4;
      15:      a = 20'sd2;
      16:      a = 20'sd1;
      default: a = 20'sd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

>>> sv/polar_go_to_goal_controller_core.sv
// Top level of the polar go-to-goal controller: config, pipeline, output buffering.
`default_nettype none

// Takes one odometry pose per request (Q16.16 position, Q1.14 quaternion) and
// returns one command request per pose: linear velocity kp*rho, angular velocity
// ka*alpha + kb*beta (both Q16.16, the linear one saturated, both zero when rho
// is within the stop tolerance) and the distance rho itself. Fully pipelined: one
// pose per cycle enters whenever in_ready_o is high. The longer of the bit-serial
// square-root pipe (34 stages) and the CORDIC pipe (CordicIterations + 8 stages)
// sets the depth of the pipeline. A two-entry output buffer (output register plus
// skid) decouples the sides, so in_ready_o is registered and the pipeline only
// stops once a second finished result is waiting. Configuration registers are
// written through cfg_we_i/cfg_idx_i/cfg_wdata_i and should only change while no
// pose is in flight; unknown indices are ignored.

module polar_go_to_goal_controller_core import pgg_pkg::*; #(
  parameter int CordicIterations = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire pgg_in_t     in_req_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output pgg_out_t         out_req_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i
);

  localparam int LatC  = CordicIterations + 8;
  localparam int LatU  = (SqrtLat > LatC) ? SqrtLat : LatC;
  localparam int NStg  = LatU + 4;

  // ---------------------------------------------------------------- config
  logic signed [31:0] goal_x_q, goal_y_q;
  logic        [15:0] gain_dist_q;
  logic signed [15:0] gain_head_q, gain_bear_q;
  logic        [31:0] stop_tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_x_q    <= '0;
      goal_y_q    <= '0;
      gain_dist_q <= 16'd819;
      gain_head_q <= 16'sd2048;
      gain_bear_q <= '0;
      stop_tol_q  <= 32'd13107;
    end else if (cfg_we_i) begin
      unique case (pgg_reg_e'(cfg_idx_i))
        REG_GOAL_X:       goal_x_q    <= cfg_wdata_i;
        REG_GOAL_Y:       goal_y_q    <= cfg_wdata_i;
        REG_GAIN_DIST:    gain_dist_q <= cfg_wdata_i[15:0];
        REG_GAIN_HEADING: gain_head_q <= cfg_wdata_i[15:0];
        REG_GAIN_BEARING: gain_bear_q <= cfg_wdata_i[15:0];
        REG_STOP_TOL:     stop_tol_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow
  // Whole pipe moves as one; it halts only while the skid entry is full.
  logic adv;
  logic skid_v_q, out_v_q;
  logic vld_q [NStg];

  assign adv        = ~skid_v_q;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NStg; k++) vld_q[k] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_valid_i;
      for (int k = 1; k < NStg; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // ---------------------------------------------------------------- stage A
  // goal offsets and quaternion products
  logic signed [32:0] dx_q, dy_q;
  logic signed [31:0] pwz_q, pxy_q, pyy_q, pzz_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx_q  <= 33'(goal_x_q) - 33'(in_req_i.pos_x);
      dy_q  <= 33'(goal_y_q) - 33'(in_req_i.pos_y);
      pwz_q <= in_req_i.quat_w * in_req_i.quat_z;
      pxy_q <= in_req_i.quat_x * in_req_i.quat_y;
      pyy_q <= in_req_i.quat_y * in_req_i.quat_y;
      pzz_q <= in_req_i.quat_z * in_req_i.quat_z;
    end
  end

  // ---------------------------------------------------------------- stage B
  // yaw operands, magnitudes for the distance
  logic signed [33:0] num_q;
  logic signed [34:0] den_q;
  logic signed [32:0] dxb_q, dyb_q;
  logic        [32:0] adx, ady;
  logic        [31:0] ax_q, ay_q;
  logic               big_q;

  assign adx = (dx_q < 0) ? 33'(-dx_q) : 33'(dx_q);
  assign ady = (dy_q < 0) ? 33'(-dy_q) : 33'(dy_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num_q <= (34'(pwz_q) + 34'(pxy_q)) <<< 1;
      den_q <= 35'sd268435456 - ((35'(pyy_q) + 35'(pzz_q)) <<< 1);
      dxb_q <= dx_q;
      dyb_q <= dy_q;
      ax_q  <= adx[31:0];
      ay_q  <= ady[31:0];
      big_q <= adx[32] | ady[32];
    end
  end

  // ---------------------------------------------------------------- units
  logic        [31:0]         rho_u;
  logic signed [OutAngW-1:0]  yaw_u, atb_u;

  pgg_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .ax_i   (ax_q),
    .ay_i   (ay_q),
    .big_i  (big_q),
    .root_o (rho_u)
  );

  pgg_cordic #(.Iterations(CordicIterations)) u_yaw (
    .clk_i (clk_i),
    .en_i  (adv),
    .y_i   (InW'(num_q)),
    .x_i   (InW'(den_q)),
    .ang_o (yaw_u)
  );

  pgg_cordic #(.Iterations(CordicIterations)) u_bearing (
    .clk_i (clk_i),
    .en_i  (adv),
    .y_i   (InW'(dyb_q)),
    .x_i   (InW'(dxb_q)),
    .ang_o (atb_u)
  );

  // align the shorter unit to the longer one
  logic        [31:0]        rho_a;
  logic signed [OutAngW-1:0] yaw_a, atb_a;

  if (LatC > SqrtLat) begin : g_dly_rho
    localparam int D = LatC - SqrtLat;
    logic [31:0] dl_q [D];
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dl_q[0] <= rho_u;
        for (int k = 1; k < D; k++) dl_q[k] <= dl_q[k-1];
      end
    end
    assign rho_a = dl_q[D-1];
    assign yaw_a = yaw_u;
    assign atb_a = atb_u;
  end else if (SqrtLat > LatC) begin : g_dly_ang
    localparam int D = SqrtLat - LatC;
    logic [2*OutAngW-1:0] dl_q [D];
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dl_q[0] <= {yaw_u, atb_u};
        for (int k = 1; k < D; k++) dl_q[k] <= dl_q[k-1];
      end
    end
    assign rho_a = rho_u;
    assign yaw_a = dl_q[D-1][2*OutAngW-1:OutAngW];
    assign atb_a = dl_q[D-1][OutAngW-1:0];
  end else begin : g_no_dly
    assign rho_a = rho_u;
    assign yaw_a = yaw_u;
    assign atb_a = atb_u;
  end

  // ---------------------------------------------------------------- stage C
  // beta = -atan2(dy,dx), alpha = -beta - yaw; gain products
  logic signed [17:0] beta, alpha;
  logic        [47:0] pv_q;
  logic signed [33:0] pa_q, pb_q;
  logic        [31:0] rho_c_q;
  logic               stop_q;

  assign beta  = -18'(atb_a);
  assign alpha = 18'(atb_a) - 18'(yaw_a);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pv_q    <= gain_dist_q * rho_a;
      pa_q    <= gain_head_q * alpha;
      pb_q    <= gain_bear_q * beta;
      rho_c_q <= rho_a;
      stop_q  <= (rho_a <= stop_tol_q);
    end
  end

  // ---------------------------------------------------------------- stage D
  logic        [48:0] vs;
  logic        [36:0] vsh;
  logic signed [34:0] os;
  logic signed [25:0] osh;
  pgg_out_t           res_d, res_q;

  assign vs  = 49'(pv_q) + 49'd2048;
  assign vsh = vs[48:12];
  assign os  = 35'(pa_q) + 35'(pb_q) + 35'sd256;
  assign osh = os[34:9];

  // omega stays well inside 32 bits (|alpha|,|beta| < 2^17), so no clamp is needed
  always_comb begin
    res_d.dist_to_goal = rho_c_q;
    if (stop_q) begin
      res_d.linear_velocity  = '0;
      res_d.angular_velocity = '0;
    end else begin
      res_d.linear_velocity  = (vsh[36:31] != '0) ? '1 : vsh[30:0];
      res_d.angular_velocity = 32'(osh);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) res_q <= res_d;
  end

  // ---------------------------------------------------------------- output buffer
  logic     incoming, out_free;
  logic     out_v_d, skid_v_d;
  pgg_out_t out_q, skid_q;

  assign incoming = vld_q[NStg-1] & adv;
  assign out_free = ~out_v_q | out_ready_i;

  always_comb begin
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    if (out_free) begin
      out_v_d  = skid_v_q | incoming;
      skid_v_d = 1'b0;
    end else if (incoming) begin
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_v_q) out_q <= skid_q;
      else          out_q <= res_q;
    end else if (incoming) begin
      skid_q <= res_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_req_o   = out_q;

  // ---------------------------------------------------------------- checks
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry held while output register empty");

  a_skid_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && !out_ready_i) |=> (skid_v_q && $stable(skid_q)))
    else $error("buffered request lost under stall");

  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && (out_q.dist_to_goal <= stop_tol_q)) |->
      (out_q.linear_velocity == '0 && out_q.angular_velocity == '0))
    else $error("non-zero command inside stop tolerance");

endmodule

`default_nettype wire

>>> sv/pgg_isqrt.sv
// Pipelined distance unit: squares, sum with overflow check, one root bit per stage.
`default_nettype none

module pgg_isqrt import pgg_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] ax_i,
  input  wire logic [31:0] ay_i,
  input  wire logic        big_i,
  output logic      [31:0] root_o
);

  logic [63:0] sa_q, sb_q;
  logic        big_q;
  logic [63:0] ss_q;
  logic        ovf_q;
  logic [64:0] sum;

  logic [63:0] rem_q  [32];
  logic [31:0] root_q [32];
  logic        sat_q  [32];

  assign sum = 65'(sa_q) + 65'(sb_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sa_q  <= ax_i * ax_i;
      sb_q  <= ay_i * ay_i;
      big_q <= big_i;
      ss_q  <= sum[63:0];
      ovf_q <= big_q | sum[64];
    end
  end

  // restoring square root, bit K decided in stage 31-K
  for (genvar t = 0; t < 32; t++) begin : g_bit
    localparam int K = 31 - t;
    logic [65:0] rin;
    logic [65:0] trial;
    logic [31:0] rt;
    logic        sat;

    if (t == 0) begin : g_first
      assign rin = 66'(ss_q);
      assign rt  = '0;
      assign sat = ovf_q;
    end else begin : g_next
      assign rin = 66'(rem_q[t-1]);
      assign rt  = root_q[t-1];
      assign sat = sat_q[t-1];
    end

    assign trial = (66'(rt) << (K + 1)) + (66'd1 << (2 * K));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sat_q[t] <= sat;
        if (rin >= trial) begin
          rem_q[t]  <= 64'(rin - trial);
          root_q[t] <= rt | (32'd1 << K);
        end else begin
          rem_q[t]  <= 64'(rin);
          root_q[t] <= rt;
        end
      end
    end
  end

  assign root_o = sat_q[31] ? '1 : root_q[31];

endmodule

`default_nettype wire

>>> sv/pgg_cordic.sv
// Pipelined vectoring CORDIC atan2: normalise, quadrant fold, iterate, round to Q13.
`default_nettype none

module pgg_cordic import pgg_pkg::*; #(
  parameter int Iterations = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic signed [InW-1:0]      y_i,
  input  wire logic signed [InW-1:0]      x_i,
  output logic      signed [OutAngW-1:0]  ang_o
);

  localparam int NSteps = 6;

  logic signed [InW:0]     xe, ye, xa, ya;
  logic signed [CordicW-1:0] ix, iy;
  logic [NormW-1:0]        im;
  logic                    iz;

  assign xe = (InW+1)'(x_i);
  assign ye = (InW+1)'(y_i);
  assign xa = (xe < 0) ? -xe : xe;
  assign ya = (ye < 0) ? -ye : ye;
  assign ix = CordicW'(x_i);
  assign iy = CordicW'(y_i);
  assign im = NormW'(xa) | NormW'(ya);
  assign iz = (x_i == '0) && (y_i == '0);

  // normalise: shift left until the larger magnitude reaches 2^40
  logic signed [CordicW-1:0] nx_q [NSteps];
  logic signed [CordicW-1:0] ny_q [NSteps];
  logic [NormW-1:0]          nm_q [NSteps];
  logic                      nz_q [NSteps];

  for (genvar j = 0; j < NSteps; j++) begin : g_norm
    localparam int Sh = 32 >> j;
    logic signed [CordicW-1:0] sx, sy;
    logic [NormW-1:0]          sm;
    logic                      sz;
    logic                      do_sh;

    if (j == 0) begin : g_first
      assign sx = ix;
      assign sy = iy;
      assign sm = im;
      assign sz = iz;
    end else begin : g_next
      assign sx = nx_q[j-1];
      assign sy = ny_q[j-1];
      assign sm = nm_q[j-1];
      assign sz = nz_q[j-1];
    end

    assign do_sh = (sm[NormW-1 -: Sh] == '0);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nx_q[j] <= do_sh ? (sx <<< Sh) : sx;
        ny_q[j] <= do_sh ? (sy <<< Sh) : sy;
        nm_q[j] <= do_sh ? (sm << Sh) : sm;
        nz_q[j] <= sz;
      end
    end
  end

  // fold the left half plane by +-pi/2
  logic signed [CordicW-1:0] px_q, py_q;
  logic signed [AngW-1:0]    pz_q;
  logic                      pzf_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pzf_q <= nz_q[NSteps-1];
      if (nx_q[NSteps-1] < 0) begin
        if (ny_q[NSteps-1] >= 0) begin
          px_q <= ny_q[NSteps-1];
          py_q <= -nx_q[NSteps-1];
          pz_q <= HalfPiQ16;
        end else begin
          px_q <= -ny_q[NSteps-1];
          py_q <= nx_q[NSteps-1];
          pz_q <= -HalfPiQ16;
        end
      end else begin
        px_q <= nx_q[NSteps-1];
        py_q <= ny_q[NSteps-1];
        pz_q <= '0;
      end
    end
  end

  logic signed [CordicW-1:0] cx_q [Iterations];
  logic signed [CordicW-1:0] cy_q [Iterations];
  logic signed [AngW-1:0]    cz_q [Iterations];
  logic                      cf_q [Iterations];

  for (genvar i = 0; i < Iterations; i++) begin : g_iter
    localparam logic signed [AngW-1:0] A = atan_q16(i);
    logic signed [CordicW-1:0] sx, sy;
    logic signed [AngW-1:0]    sz;
    logic                      sf;

    if (i == 0) begin : g_first
      assign sx = px_q;
      assign sy = py_q;
      assign sz = pz_q;
      assign sf = pzf_q;
    end else begin : g_next
      assign sx = cx_q[i-1];
      assign sy = cy_q[i-1];
      assign sz = cz_q[i-1];
      assign sf = cf_q[i-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cf_q[i] <= sf;
        if (sy > 0) begin
          cx_q[i] <= sx + (sy >>> i);
          cy_q[i] <= sy - (sx >>> i);
          cz_q[i] <= sz + A;
        end else begin
          cx_q[i] <= sx - (sy >>> i);
          cy_q[i] <= sy + (sx >>> i);
          cz_q[i] <= sz - A;
        end
      end
    end
  end

  // round half up to Q13, zero vector gives zero
  logic signed [AngW-1:0] zr;
  assign zr = cz_q[Iterations-1] + AngW'(4);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ang_o <= cf_q[Iterations-1] ? '0 : zr[AngW-1:3];
    end
  end

endmodule

`default_nettype wire

>>> dv/tb_polar_go_to_goal_controller_core.sv
// Self-checking testbench for the polar go-to-goal controller core.
`default_nettype none

module tb_polar_go_to_goal_controller_core import pgg_pkg::*; ();

  localparam int Iters    = 16;
  localparam int Latency  = 5 + ((Iters + 8) > SqrtLat ? (Iters + 8) : SqrtLat);
  localparam int IdleLim  = 20000;
  localparam longint NormLim = 64'sd1 << 40;

  logic        clk, rst_n;
  logic        in_valid = 1'b0;
  logic        out_ready = 1'b0;
  logic        in_ready, out_valid;
  pgg_in_t     in_req = '0;
  pgg_out_t    out_req;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [31:0] cfg_wdata;

  polar_go_to_goal_controller_core #(.CordicIterations(Iters)) uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_req_i(in_req),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_req_o(out_req),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata)
  );

  // shadow of the block's registers
  logic signed [31:0] sh_goal_x, sh_goal_y;
  logic        [15:0] sh_kp;
  logic signed [15:0] sh_ka, sh_kb;
  logic        [31:0] sh_tol;

  pgg_in_t  pose_q[$];
  pgg_out_t cmd_q[$];

  int send_idle_pct, recv_stall_pct;
  bit hold_recv;
  bit in_acc = 1'b0;
  int errors = 0, n_sent = 0, n_got = 0, idle_cnt = 0, n_inside = 0, n_sat = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint angle_q13(longint y, longint x);
    longint z, a, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    while (abs64(x) < NormLim && abs64(y) < NormLim) begin
      x = x * 2;
      y = y * 2;
    end
    if (x < 0) begin
      xs = x;
      if (y >= 0) begin
        x = y; y = -xs; z = longint'(HalfPiQ16);
      end else begin
        x = -y; y = xs; z = -longint'(HalfPiQ16);
      end
    end
    for (int i = 0; i < Iters; i++) begin
      a = longint'(atan_q16(i));
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (y > 0) begin
        x = x + ys; y = y - xs; z = z + a;
      end else begin
        x = x - ys; y = y + xs; z = z - a;
      end
    end
    return floor_shr(z + 4, 3);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s = s - (res + b);
        res = (res >> 1) + b;
      end else res = res >> 1;
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic pgg_out_t predict_cmd(pgg_in_t p);
    pgg_out_t r;
    longint dx, dy, qx, qy, qz, qw, num, den, yaw, beta, alpha, om;
    longint unsigned ax, ay, sa, ss, rho, v;
    dx = longint'(sh_goal_x) - longint'(p.pos_x);
    dy = longint'(sh_goal_y) - longint'(p.pos_y);
    ax = abs64(dx);
    ay = abs64(dy);
    if (ax > 64'hFFFF_FFFF || ay > 64'hFFFF_FFFF) rho = 64'hFFFF_FFFF;
    else begin
      sa = ax * ax;
      ss = sa + ay * ay;
      rho = (ss < sa) ? 64'hFFFF_FFFF : int_sqrt(ss);
    end
    qx = p.quat_x; qy = p.quat_y; qz = p.quat_z; qw = p.quat_w;
    num = 2 * (qw * qz + qx * qy);
    den = (64'sd1 <<< 28) - 2 * (qy * qy + qz * qz);
    yaw = angle_q13(num, den);
    beta = -angle_q13(dy, dx);
    alpha = -beta - yaw;
    v = (longint'(sh_kp) * rho + 2048) >> 12;
    if (v > 64'h7FFF_FFFF) v = 64'h7FFF_FFFF;
    om = floor_shr(longint'(sh_ka) * alpha + longint'(sh_kb) * beta + 256, 9);
    if (om > 64'sd2147483647) om = 64'sd2147483647;
    if (om < -64'sd2147483648) om = -64'sd2147483648;
    if (rho <= sh_tol) begin
      v = 0; om = 0;
    end
    r.linear_velocity  = v[30:0];
    r.angular_velocity = om[31:0];
    r.dist_to_goal     = rho[31:0];
    return r;
  endfunction

  // driver: payload held until accepted, change on falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_acc) begin
        if (pose_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_req   <= pose_q.pop_front();
          in_valid <= 1'b1;
        end else in_valid <= 1'b0;
      end
      out_ready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    pgg_out_t e;
    if (rst_n) begin
      in_acc = in_valid && in_ready;
      if (in_acc) begin
        cmd_q.push_back(predict_cmd(in_req));
        n_sent++;
      end
      if (in_acc || (out_valid && out_ready)) idle_cnt = 0;
      else idle_cnt++;
      if (idle_cnt >= IdleLim) begin
        $display("tb: failure");
        $finish;
      end
      if (out_valid && out_ready) begin
        n_got++;
        if (cmd_q.size() == 0) begin
          $error("unexpected command request %h", out_req);
          errors++;
        end else begin
          e = cmd_q.pop_front();
          if (e.dist_to_goal == 0 || out_req.dist_to_goal <= sh_tol) n_inside++;
          if (e.linear_velocity == 31'h7FFF_FFFF) n_sat++;
          if (out_req.linear_velocity !== e.linear_velocity) begin
            $error("linear_velocity exp %h got %h", e.linear_velocity,
                   out_req.linear_velocity);
            errors++;
          end
          if (out_req.angular_velocity !== e.angular_velocity) begin
            $error("angular_velocity exp %h got %h", e.angular_velocity,
                   out_req.angular_velocity);
            errors++;
          end
          if (out_req.dist_to_goal !== e.dist_to_goal) begin
            $error("dist_to_goal exp %h got %h", e.dist_to_goal,
                   out_req.dist_to_goal);
            errors++;
          end
        end
      end
    end
  end

  task automatic write_reg(pgg_reg_e idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_GOAL_X:       sh_goal_x = val;
      REG_GOAL_Y:       sh_goal_y = val;
      REG_GAIN_DIST:    sh_kp = val[15:0];
      REG_GAIN_HEADING: sh_ka = val[15:0];
      REG_GAIN_BEARING: sh_kb = val[15:0];
      REG_STOP_TOL:     sh_tol = val;
      default: ;
    endcase
  endtask

  // checked on the rising edge, where the driver's outputs are settled
  task automatic drain();
    while (pose_q.size() != 0 || in_valid || cmd_q.size() != 0) @(posedge clk);
    repeat (Latency + 4) @(negedge clk);
  endtask

  function automatic logic [15:0] rand_quat();
    case ($urandom_range(3))
      0: return 16'(int'($urandom_range(32768)) - 16384);
      1: return $urandom_range(1) ? 16'sd16384 : -16'sd16384;
      2: return 16'($urandom);
      default: return 16'(int'($urandom_range(2000)) - 1000);
    endcase
  endfunction

  function automatic logic [31:0] rand_pos(logic [31:0] goal);
    case ($urandom_range(4))
      0: return $urandom;
      1: return goal + 32'(int'($urandom_range(40000)) - 20000);
      2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return goal + 32'(int'($urandom_range(2000000)) - 1000000);
    endcase
  endfunction

  task automatic add_pose(logic [31:0] px, logic [31:0] py,
                          logic [15:0] qx, logic [15:0] qy,
                          logic [15:0] qz, logic [15:0] qw);
    pgg_in_t p;
    p.pos_x = px; p.pos_y = py;
    p.quat_x = qx; p.quat_y = qy; p.quat_z = qz; p.quat_w = qw;
    pose_q.push_back(p);
  endtask

  task automatic random_poses(int n);
    repeat (n) add_pose(rand_pos(sh_goal_x), rand_pos(sh_goal_y),
                        rand_quat(), rand_quat(), rand_quat(), rand_quat());
  endtask

  task automatic random_config();
    write_reg(REG_GOAL_X, $urandom_range(3) == 0 ? $urandom : 32'($urandom_range(600000)));
    write_reg(REG_GOAL_Y, $urandom);
    write_reg(REG_GAIN_DIST, $urandom);
    write_reg(REG_GAIN_HEADING, $urandom);
    write_reg(REG_GAIN_BEARING, $urandom);
    write_reg(REG_STOP_TOL, $urandom_range(1) ? 32'($urandom_range(70000)) : $urandom);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_idx = REG_GOAL_X; cfg_wdata = '0;
    sh_goal_x = 0; sh_goal_y = 0; sh_kp = 16'd819; sh_ka = 16'sd2048;
    sh_kb = 16'sd0; sh_tol = 32'd13107;
    send_idle_pct = 0; recv_stall_pct = 0; hold_recv = 0;
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // directed: reset config, goal hit, zero quaternion, extremes
    add_pose(0, 0, 0, 0, 0, 0);
    add_pose(0, 0, 0, 0, 0, 16'sd16384);
    add_pose(32'd13107, 0, 0, 0, 16'sd16384, 0);
    add_pose(32'd13108, 0, 0, 0, 16'sd11585, 16'sd11585);
    add_pose(32'h8000_0000, 32'h8000_0000, -16'sd16384, -16'sd16384,
             -16'sd16384, -16'sd16384);
    add_pose(32'h7FFF_FFFF, 32'h8000_0000, 16'sd16384, 16'sd16384,
             16'sd16384, 16'sd16384);
    add_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h5555);
    add_pose(32'h0001_0000, 32'hFFFF_0000, 0, 16'sd16384, 0, 0);
    add_pose(32'hFFFF_0000, 0, 0, 0, -16'sd16384, 16'sd1);
    add_pose(0, 32'h0001_0000, 16'sd100, -16'sd200, 16'sd300, -16'sd400);
    drain();

    // register extremes: far goal, full gains, zero tolerance, bad index
    write_reg(REG_GOAL_X, 32'h8000_0000);
    write_reg(REG_GOAL_Y, 32'h7FFF_FFFF);
    write_reg(REG_GAIN_DIST, 16'hFFFF);
    write_reg(REG_GAIN_HEADING, 16'h8000);
    write_reg(REG_GAIN_BEARING, 16'h7FFF);
    write_reg(REG_STOP_TOL, 0);
    write_reg(pgg_reg_e'(3'd7), 32'hDEAD_BEEF);
    add_pose(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 16'sd16384);
    add_pose(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0);
    add_pose(0, 0, 16'sd16384, 0, 0, 0);
    add_pose(32'h8000_0001, 32'h7FFF_FFFE, 0, 0, 16'sd16384, 16'sd16384);
    drain();
    write_reg(REG_STOP_TOL, 32'hFFFF_FFFF);
    add_pose(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 16'sd16384);
    drain();
    write_reg(REG_GAIN_HEADING, 16'h7FFF);
    write_reg(REG_GAIN_BEARING, 16'h8000);
    write_reg(REG_GAIN_DIST, 0);
    write_reg(REG_STOP_TOL, 0);
    add_pose(32'h7FFF_FFFF, 32'h8000_0000, 16'sd16384, 0, 0, 0);
    add_pose(32'h0000_0001, 32'h7FFF_FFFF, 0, 0, 16'sd16384, -16'sd16384);
    drain();

    // random phases under varying back-pressure
    for (int ph = 0; ph < 8; ph++) begin
      random_config();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      if (ph == 2) begin
        // long receiver hold-off while poses keep coming: pipeline fills
        hold_recv = 1'b1;
        random_poses(90);
        repeat (300) @(negedge clk);
        hold_recv = 1'b0;
      end else random_poses(90);
      drain();
    end

    $display("tb: %0d poses sent, %0d commands checked,", n_sent, n_got);
    $display("tb: %0d inside tolerance, %0d speed-saturated", n_inside, n_sat);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
